>>> sv/pad_input_recipe_sequencer_unit_defines.svh
// assertion macros for the pad input recipe sequencer
`ifndef PAD_INPUT_RECIPE_SEQUENCER_UNIT_DEFINES_SVH
`define PAD_INPUT_RECIPE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication under the block clock and reset
`define PIRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under the block clock and reset
`define PIRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pirs_pkg.sv
// shared types and codes of the pad input recipe sequencer
`default_nettype none
package pirs_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [3:0] KIND_WAIT  = 4'd0;
    localparam logic [3:0] KIND_PRESS = 4'd1;
    localparam logic [3:0] KIND_HOLD  = 4'd2;
    localparam logic [3:0] KIND_UNTIL = 4'd3;
    localparam logic [3:0] KIND_SEEK  = 4'd4;
    localparam logic [3:0] KIND_SHOT  = 4'd5;
    localparam logic [3:0] KIND_POKE  = 4'd6;
    localparam logic [3:0] KIND_SKIP  = 4'd7;
    localparam logic [3:0] KIND_END   = 4'd8;

    localparam logic [1:0] OP_EQ   = 2'd0;
    localparam logic [1:0] OP_NE   = 2'd1;
    localparam logic [1:0] OP_ANY  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] WIDTH_BYTE = 2'd0;
    localparam logic [1:0] WIDTH_HALF = 2'd1;
    localparam logic [1:0] WIDTH_WORD = 2'd2;

    localparam logic [1:0] STATUS_RUN  = 2'd0;
    localparam logic [1:0] STATUS_DONE = 2'd1;
    localparam logic [1:0] STATUS_FAIL = 2'd2;

    localparam logic RES_FRAME = 1'b0;
    localparam logic RES_WRITE = 1'b1;

    localparam int MAX_POKES = 63;

    typedef struct packed {
        logic        command;
        logic [5:0]  step_index;
        logic [3:0]  step_kind;
        logic [15:0] step_buttons;
        logic [15:0] step_count;
        logic [7:0]  step_hold;
        logic [7:0]  step_gap;
        logic [1:0]  step_op;
        logic [31:0] step_addr;
        logic [1:0]  step_width;
        logic [31:0] step_value;
        logic [31:0] probe_value;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] pad_held;
        logic [15:0] pad_previous;
        logic [15:0] pad_pressed;
        logic [31:0] write_addr;
        logic [1:0]  write_width;
        logic [31:0] write_value;
        logic [31:0] probe_addr;
        logic [1:0]  probe_width;
        logic [1:0]  status;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] buttons;
        logic [15:0] count;
        logic [7:0]  hold;
        logic [7:0]  gap;
        logic [1:0]  op;
        logic [1:0]  width;
        logic [31:0] addr;
        logic [31:0] value;
    } step_rec_t;

    function automatic logic [1:0] norm_width(input logic [1:0] w);
        return (w > WIDTH_WORD) ? WIDTH_WORD : w;
    endfunction

endpackage
`default_nettype wire

>>> sv/pirs_step_store.sv
// program store: one write port, one registered read port
`default_nettype none
module pirs_step_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire pirs_pkg::step_rec_t wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output pirs_pkg::step_rec_t     rd_data
);
    pirs_pkg::step_rec_t mem [DEPTH];
    pirs_pkg::step_rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

>>> sv/pirs_cond_unit.sv
// watched-value comparison shared by until and seek steps
`default_nettype none
module pirs_cond_unit (
    input  wire logic [31:0] probe,
    input  wire logic [31:0] operand,
    input  wire logic [1:0]  width,
    input  wire logic [1:0]  op,
    output logic             holds
);
    logic [31:0] v;

    always_comb begin
        case (pirs_pkg::norm_width(width))
            pirs_pkg::WIDTH_BYTE: v = {24'd0, probe[7:0]};
            pirs_pkg::WIDTH_HALF: v = {16'd0, probe[15:0]};
            default:              v = probe;
        endcase
        case (op)
            pirs_pkg::OP_EQ:  holds = (v == operand);
            pirs_pkg::OP_NE:  holds = (v != operand);
            pirs_pkg::OP_ANY: holds = ((v & operand) != 32'd0);
            default:          holds = ((v & operand) == 32'd0);
        endcase
    end
endmodule
`default_nettype wire

>>> sv/pad_input_recipe_sequencer_unit.sv
// top level of the pad input recipe sequencer
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_data  (pirs_pkg::in_t)
// m_       out  m_valid/m_ready    m_data  (pirs_pkg::out_t)
// cfg_     in   cfg_wen            cfg_wdata (program length)
// a load is written to the store as it is accepted; a tick walks each step through fetch and evaluate,
// with a poke state for each poke and a frame state that closes the tick
// each step is read through the program store read port and judged by the single step evaluator
// no clearing pass after reset: the store is undefined until loaded
// a full result register stalls the walk until m_ready; s_ready is low during a tick
`default_nettype none
`include "pad_input_recipe_sequencer_unit_defines.svh"
module pad_input_recipe_sequencer_unit #(
    parameter int PROGRAM_DEPTH = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire pirs_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pirs_pkg::out_t      m_data,
    input  wire logic           cfg_wen,
    input  wire logic [6:0]     cfg_wdata
);
    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH + 1);
    localparam int CW = (PW > 7) ? PW : 7;
    localparam logic [CW-1:0] DEPTH_C = CW'(PROGRAM_DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_POKE  = 3'd3;
    localparam logic [2:0] ST_FRAME = 3'd4;

    logic [2:0]     state_reg, state_next;
    logic [6:0]     plen_reg;
    logic [PW-1:0]  ptr_reg, ptr_next;
    logic [16:0]    t_reg, t_next;
    logic [8:0]     phase_reg, phase_next;
    logic [16:0]    quot_reg, quot_next;
    logic           playing_reg, playing_next;
    logic           failed_reg, failed_next;
    logic           pvalid_reg, pvalid_next;
    logic           fresh_reg, fresh_next;
    logic [15:0]    cur_reg, cur_next;
    logic [15:0]    prev_reg, prev_next;
    logic [15:0]    word_reg, word_next;
    logic [1:0]     outcome_reg, outcome_next;
    logic [5:0]     pokes_reg, pokes_next;
    logic [31:0]    probe_reg, probe_next;
    logic           m_valid_reg, m_valid_next;
    pirs_pkg::out_t m_data_reg, m_data_next;

    pirs_pkg::step_rec_t wr_rec, rd_rec;
    logic           wr_en, rd_en, cond_ok, out_free, at_end, accept;
    logic [CW-1:0]  len_eff;
    logic [8:0]     per, perx, phase_inc;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign len_eff  = (CW'(plen_reg) > DEPTH_C) ? DEPTH_C : CW'(plen_reg);
    assign at_end   = (CW'(ptr_reg) >= len_eff);
    assign rd_en    = (state_reg == ST_FETCH) && !at_end;
    assign wr_en    = accept && (s_data.command == pirs_pkg::CMD_LOAD)
                      && (32'(s_data.step_index) < PROGRAM_DEPTH);
    assign per       = {1'b0, rd_rec.hold} + {1'b0, rd_rec.gap};
    assign perx      = (per == 9'd0) ? 9'd1 : per;
    assign phase_inc = phase_reg + 9'd1;

    always_comb begin
        wr_rec.kind    = s_data.step_kind;
        wr_rec.buttons = s_data.step_buttons;
        wr_rec.count   = s_data.step_count;
        wr_rec.hold    = s_data.step_hold;
        wr_rec.gap     = s_data.step_gap;
        wr_rec.op      = s_data.step_op;
        wr_rec.width   = s_data.step_width;
        wr_rec.addr    = s_data.step_addr;
        wr_rec.value   = s_data.step_value;
    end

    pirs_step_store #(.DEPTH(PROGRAM_DEPTH), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_data.step_index)),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[AW-1:0]),
        .rd_data (rd_rec)
    );

    pirs_cond_unit u_cond (
        .probe   (probe_reg),
        .operand (rd_rec.value),
        .width   (rd_rec.width),
        .op      (rd_rec.op),
        .holds   (cond_ok)
    );

    always_comb begin
        logic adv, stop_f;
        adv          = 1'b0;
        stop_f       = 1'b0;
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        t_next       = t_reg;
        phase_next   = phase_reg;
        quot_next    = quot_reg;
        playing_next = playing_reg;
        failed_next  = failed_reg;
        pvalid_next  = pvalid_reg;
        fresh_next   = fresh_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        word_next    = word_reg;
        outcome_next = outcome_reg;
        pokes_next   = pokes_reg;
        probe_next   = probe_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.command == pirs_pkg::CMD_LOAD) begin
                        pvalid_next = 1'b0;
                    end else begin
                        probe_next = s_data.probe_value;
                        fresh_next = pvalid_reg;
                        pokes_next = 6'd0;
                        word_next  = 16'd0;
                        if (playing_reg) begin
                            outcome_next = pirs_pkg::STATUS_RUN;
                            state_next   = ST_FETCH;
                        end else begin
                            outcome_next = failed_reg ? pirs_pkg::STATUS_FAIL
                                                      : pirs_pkg::STATUS_DONE;
                            state_next   = ST_FRAME;
                        end
                    end
                end
            end
            ST_FETCH: begin
                if (at_end) begin
                    outcome_next = pirs_pkg::STATUS_DONE;
                    state_next   = ST_FRAME;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                case (rd_rec.kind)
                    pirs_pkg::KIND_WAIT, pirs_pkg::KIND_HOLD, pirs_pkg::KIND_SHOT: begin
                        if (t_reg < {1'b0, rd_rec.count}) begin
                            t_next    = t_reg + 17'd1;
                            word_next = (rd_rec.kind == pirs_pkg::KIND_WAIT) ? 16'd0
                                                                             : rd_rec.buttons;
                            stop_f    = 1'b1;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    pirs_pkg::KIND_PRESS: begin
                        if (per != 9'd0 && quot_reg < {1'b0, rd_rec.count}) begin
                            word_next = (phase_reg < {1'b0, rd_rec.hold}) ? rd_rec.buttons
                                                                          : 16'd0;
                            stop_f    = 1'b1;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    pirs_pkg::KIND_UNTIL: begin
                        if (!fresh_reg) begin
                            word_next = 16'd0;
                            stop_f    = 1'b1;
                        end else if (cond_ok) begin
                            adv = 1'b1;
                        end else if (t_reg >= {1'b0, rd_rec.count}) begin
                            outcome_next = pirs_pkg::STATUS_FAIL;
                            stop_f       = 1'b1;
                        end else begin
                            t_next    = t_reg + 17'd1;
                            word_next = 16'd0;
                            stop_f    = 1'b1;
                        end
                    end
                    pirs_pkg::KIND_SEEK: begin
                        // the condition is checked only at a press boundary
                        if (phase_reg == 9'd0 && !fresh_reg) begin
                            word_next = 16'd0;
                            stop_f    = 1'b1;
                        end else if (phase_reg == 9'd0 && cond_ok) begin
                            adv = 1'b1;
                        end else if (phase_reg == 9'd0 && quot_reg >= {1'b0, rd_rec.count}) begin
                            outcome_next = pirs_pkg::STATUS_FAIL;
                            stop_f       = 1'b1;
                        end else begin
                            word_next = (phase_reg < {1'b0, rd_rec.hold}) ? rd_rec.buttons
                                                                          : 16'd0;
                            stop_f    = 1'b1;
                        end
                    end
                    pirs_pkg::KIND_POKE: begin
                        if (pokes_reg == 6'(pirs_pkg::MAX_POKES)) begin
                            word_next = 16'd0;
                            stop_f    = 1'b1;
                        end else begin
                            state_next = ST_POKE;
                        end
                    end
                    pirs_pkg::KIND_END: begin
                        outcome_next = pirs_pkg::STATUS_DONE;
                        stop_f       = 1'b1;
                    end
                    default: begin
                        adv = 1'b1;
                    end
                endcase
                // press and seek frames step the phase counter
                if (stop_f && outcome_next == pirs_pkg::STATUS_RUN
                    && (rd_rec.kind == pirs_pkg::KIND_PRESS
                        || (rd_rec.kind == pirs_pkg::KIND_SEEK
                            && !(phase_reg == 9'd0 && !fresh_reg)))) begin
                    if (phase_inc == perx) begin
                        phase_next = 9'd0;
                        quot_next  = quot_reg + 17'd1;
                    end else begin
                        phase_next = phase_inc;
                    end
                end
                if (stop_f) begin
                    state_next = ST_FRAME;
                end
            end
            ST_POKE: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next              = '0;
                    m_data_next.result_kind  = pirs_pkg::RES_WRITE;
                    m_data_next.write_addr   = rd_rec.addr;
                    m_data_next.write_width  = pirs_pkg::norm_width(rd_rec.width);
                    m_data_next.write_value  = rd_rec.value;
                    pokes_next               = pokes_reg + 6'd1;
                    adv                      = 1'b1;
                end
            end
            ST_FRAME: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next.result_kind = pirs_pkg::RES_FRAME;
                    m_data_next.last        = 1'b1;
                    m_data_next.status      = outcome_reg;
                    state_next              = ST_IDLE;
                    if (playing_reg) begin
                        prev_next   = cur_reg;
                        pvalid_next = 1'b0;
                        if (outcome_reg != pirs_pkg::STATUS_RUN) begin
                            cur_next     = 16'd0;
                            playing_next = 1'b0;
                            failed_next  = (outcome_reg == pirs_pkg::STATUS_FAIL);
                        end else begin
                            cur_next                 = word_reg;
                            m_data_next.pad_held     = word_reg;
                            m_data_next.pad_previous = cur_reg;
                            m_data_next.pad_pressed  = (word_reg ^ cur_reg) & word_reg;
                            if (rd_rec.kind == pirs_pkg::KIND_UNTIL
                                || rd_rec.kind == pirs_pkg::KIND_SEEK) begin
                                m_data_next.probe_addr  = rd_rec.addr;
                                m_data_next.probe_width = pirs_pkg::norm_width(rd_rec.width);
                                pvalid_next             = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv) begin
            ptr_next   = ptr_reg + PW'(1);
            t_next     = 17'd0;
            phase_next = 9'd0;
            quot_next  = 17'd0;
            fresh_next = 1'b0;
            state_next = ST_FETCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            plen_reg    <= 7'd0;
            ptr_reg     <= '0;
            t_reg       <= 17'd0;
            phase_reg   <= 9'd0;
            quot_reg    <= 17'd0;
            playing_reg <= 1'b1;
            failed_reg  <= 1'b0;
            pvalid_reg  <= 1'b0;
            fresh_reg   <= 1'b0;
            cur_reg     <= 16'd0;
            prev_reg    <= 16'd0;
            outcome_reg <= pirs_pkg::STATUS_RUN;
            pokes_reg   <= 6'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_wen) begin
                plen_reg <= cfg_wdata;
            end
            ptr_reg     <= ptr_next;
            t_reg       <= t_next;
            phase_reg   <= phase_next;
            quot_reg    <= quot_next;
            playing_reg <= playing_next;
            failed_reg  <= failed_next;
            pvalid_reg  <= pvalid_next;
            fresh_reg   <= fresh_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            outcome_reg <= outcome_next;
            pokes_reg   <= pokes_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        probe_reg  <= probe_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PIRS_ASSERT_NOW(a_write_not_last, m_valid && m_data.result_kind == pirs_pkg::RES_WRITE, !m_data.last && m_data.status == pirs_pkg::STATUS_RUN, "write request marked last")
    `PIRS_ASSERT_NOW(a_stopped_no_pad, m_valid && m_data.status != pirs_pkg::STATUS_RUN, m_data.pad_held == 16'd0 && m_data.probe_addr == 32'd0, "pad word after playback ended")
    `PIRS_ASSERT_NOW(a_poke_limit, state_reg == ST_POKE, pokes_reg < 6'(pirs_pkg::MAX_POKES), "poke burst limit exceeded")
    `PIRS_ASSERT_NEXT(a_frame_ends_tick, state_reg == ST_FRAME && out_free, state_reg == ST_IDLE && m_valid && m_data.last, "frame did not close the tick")
endmodule
`default_nettype wire

>>> bench/pad_input_recipe_sequencer_unit_test.sv
// testbench for the pad input recipe sequencer: directed table, random program play, predictor check
`timescale 1ns / 100ps
module pad_input_recipe_sequencer_unit_test;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 170;

    typedef struct {
        bit               is_cfg;
        logic [6:0]       length;
        pirs_pkg::in_t    item;
    } dir_row_t;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    pirs_pkg::in_t  s_data = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    pirs_pkg::out_t m_data;
    logic  cfg_wen = 1'b0;
    logic  [6:0] cfg_wdata = '0;

    // own copy of the sequencer state
    pirs_pkg::step_rec_t prog [DEPTH];
    logic [6:0]  length_reg;
    int unsigned step_ptr;
    logic [31:0] frames_done;
    bit          is_playing;
    bit          has_failed;
    bit          probe_ok;
    logic [15:0] word_now;
    logic [15:0] word_before;

    pirs_pkg::out_t frame_q [$];
    dir_row_t    dir_tab [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;

    pad_input_recipe_sequencer_unit #(.PROGRAM_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready <= 1'b0;
            stall_left <= int'($urandom_range(0, 4));
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pirs_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected transaction, expected none actual %p", $time, m_data);
                errors++;
            end else begin
                want = frame_q.pop_front();
                if (m_data.result_kind !== want.result_kind
                    || m_data.pad_held !== want.pad_held
                    || m_data.pad_previous !== want.pad_previous
                    || m_data.pad_pressed !== want.pad_pressed
                    || m_data.write_addr !== want.write_addr
                    || m_data.write_width !== want.write_width
                    || m_data.write_value !== want.write_value
                    || m_data.probe_addr !== want.probe_addr
                    || m_data.probe_width !== want.probe_width
                    || m_data.status !== want.status
                    || m_data.last !== want.last) begin
                    $display("%0t: mismatch, expected %p actual %p", $time, want, m_data);
                    errors++;
                end
            end
        end
    end

    // expected transactions are queued in order of arrival
    task automatic expect_result(pirs_pkg::out_t r);
        frame_q.insert(frame_q.size(), r);
    endtask

    task automatic add_row(bit is_cfg, logic [6:0] length, pirs_pkg::in_t item);
        dir_row_t row;
        row.is_cfg = is_cfg;
        row.length = length;
        row.item = item;
        dir_tab.insert(dir_tab.size(), row);
    endtask

    function automatic bit cond_met(pirs_pkg::step_rec_t c, logic [31:0] probe);
        logic [31:0] v;
        case (c.width)
            pirs_pkg::WIDTH_BYTE: v = probe & 32'h0000_00ff;
            pirs_pkg::WIDTH_HALF: v = probe & 32'h0000_ffff;
            default:              v = probe;
        endcase
        case (c.op)
            pirs_pkg::OP_EQ:  return v == c.value;
            pirs_pkg::OP_NE:  return v != c.value;
            pirs_pkg::OP_ANY: return (v & c.value) != 32'd0;
            default:          return (v & c.value) == 32'd0;
        endcase
    endfunction

    function automatic pirs_pkg::out_t frame_res(logic [15:0] held, logic [15:0] prev,
                                                 logic [31:0] paddr, logic [1:0] pwidth,
                                                 logic [1:0] st);
        pirs_pkg::out_t r;
        r = '0;
        r.result_kind = pirs_pkg::RES_FRAME;
        r.pad_held = held;
        r.pad_previous = prev;
        r.pad_pressed = (held ^ prev) & held;
        r.probe_addr = paddr;
        r.probe_width = pwidth;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_frame(pirs_pkg::in_t x);
        pirs_pkg::step_rec_t c;
        pirs_pkg::out_t      wr;
        int unsigned len;
        int unsigned pokes;
        logic [31:0] t, per, phase;
        logic [1:0]  outcome;
        logic [15:0] word;
        logic [31:0] paddr;
        logic [1:0]  pwidth;
        bit          fresh, stop, adv, checked;
        if (x.command == pirs_pkg::CMD_LOAD) begin
            prog[x.step_index] = '{x.step_kind, x.step_buttons, x.step_count, x.step_hold,
                                   x.step_gap, x.step_op, x.step_width, x.step_addr,
                                   x.step_value};
            probe_ok = 1'b0;
            return;
        end
        if (!is_playing) begin
            expect_result(frame_res('0, '0, '0, '0,
                                    has_failed ? pirs_pkg::STATUS_FAIL
                                               : pirs_pkg::STATUS_DONE));
            return;
        end
        len = (32'(length_reg) > DEPTH) ? DEPTH : 32'(length_reg);
        fresh = probe_ok;
        stop = 1'b0;
        pokes = 0;
        outcome = pirs_pkg::STATUS_RUN;
        word = '0;
        while (!stop) begin
            if (step_ptr >= len) begin
                outcome = pirs_pkg::STATUS_DONE;
                break;
            end
            c = prog[step_ptr];
            t = frames_done;
            adv = 1'b0;
            case (c.kind)
                pirs_pkg::KIND_WAIT: begin
                    if (t < 32'(c.count)) begin
                        frames_done = t + 32'd1; word = '0; stop = 1'b1;
                    end else adv = 1'b1;
                end
                pirs_pkg::KIND_HOLD, pirs_pkg::KIND_SHOT: begin
                    if (t < 32'(c.count)) begin
                        frames_done = t + 32'd1; word = c.buttons; stop = 1'b1;
                    end else adv = 1'b1;
                end
                pirs_pkg::KIND_PRESS: begin
                    per = 32'(c.hold) + 32'(c.gap);
                    if (t < per * 32'(c.count)) begin
                        phase = t % per;
                        frames_done = t + 32'd1;
                        word = (phase < 32'(c.hold)) ? c.buttons : '0;
                        stop = 1'b1;
                    end else adv = 1'b1;
                end
                pirs_pkg::KIND_UNTIL: begin
                    if (!fresh) begin
                        word = '0; stop = 1'b1;
                    end else if (cond_met(c, x.probe_value)) begin
                        adv = 1'b1;
                    end else if (t >= 32'(c.count)) begin
                        outcome = pirs_pkg::STATUS_FAIL; stop = 1'b1;
                    end else begin
                        frames_done = t + 32'd1; word = '0; stop = 1'b1;
                    end
                end
                pirs_pkg::KIND_SEEK: begin
                    per = 32'(c.hold) + 32'(c.gap);
                    if (per == 32'd0) per = 32'd1;
                    phase = t % per;
                    checked = 1'b0;
                    if (phase == 32'd0) begin
                        if (!fresh) begin
                            word = '0; stop = 1'b1; checked = 1'b1;
                        end else if (cond_met(c, x.probe_value)) begin
                            adv = 1'b1; checked = 1'b1;
                        end else if (t / per >= 32'(c.count)) begin
                            outcome = pirs_pkg::STATUS_FAIL; stop = 1'b1; checked = 1'b1;
                        end
                    end
                    if (!checked) begin
                        frames_done = t + 32'd1;
                        word = (phase < 32'(c.hold)) ? c.buttons : '0;
                        stop = 1'b1;
                    end
                end
                pirs_pkg::KIND_POKE: begin
                    if (pokes >= pirs_pkg::MAX_POKES) begin
                        word = '0; stop = 1'b1;
                    end else begin
                        wr = '0;
                        wr.result_kind = pirs_pkg::RES_WRITE;
                        wr.write_addr = c.addr;
                        wr.write_width = (c.width == 2'd3) ? pirs_pkg::WIDTH_WORD : c.width;
                        wr.write_value = c.value;
                        expect_result(wr);
                        pokes++;
                        adv = 1'b1;
                    end
                end
                pirs_pkg::KIND_END: begin
                    outcome = pirs_pkg::STATUS_DONE; stop = 1'b1;
                end
                default: adv = 1'b1;
            endcase
            if (adv) begin
                step_ptr++;
                frames_done = '0;
                fresh = 1'b0;
            end
        end
        word_before = word_now;
        word_now = (outcome != pirs_pkg::STATUS_RUN) ? '0 : word;
        probe_ok = 1'b0;
        if (outcome != pirs_pkg::STATUS_RUN) begin
            is_playing = 1'b0;
            has_failed = (outcome == pirs_pkg::STATUS_FAIL);
            expect_result(frame_res('0, '0, '0, '0, outcome));
        end else begin
            paddr = '0;
            pwidth = '0;
            if (step_ptr < len && (prog[step_ptr].kind == pirs_pkg::KIND_UNTIL
                                   || prog[step_ptr].kind == pirs_pkg::KIND_SEEK)) begin
                paddr = prog[step_ptr].addr;
                pwidth = (prog[step_ptr].width == 2'd3) ? pirs_pkg::WIDTH_WORD
                                                        : prog[step_ptr].width;
                probe_ok = 1'b1;
            end
            expect_result(frame_res(word_now, word_before, paddr, pwidth,
                                    pirs_pkg::STATUS_RUN));
        end
    endtask

    function automatic pirs_pkg::in_t mk_load(int idx, logic [3:0] kind, logic [15:0] buttons,
                                              logic [15:0] count, logic [7:0] hold,
                                              logic [7:0] gap, logic [1:0] op,
                                              logic [31:0] addr, logic [1:0] width,
                                              logic [31:0] value);
        pirs_pkg::in_t x;
        x = '0;
        x.command = pirs_pkg::CMD_LOAD;
        x.step_index = 6'(idx);
        x.step_kind = kind;
        x.step_buttons = buttons;
        x.step_count = count;
        x.step_hold = hold;
        x.step_gap = gap;
        x.step_op = op;
        x.step_addr = addr;
        x.step_width = width;
        x.step_value = value;
        x.probe_value = $urandom;
        return x;
    endfunction

    // short, playable step with random content
    function automatic pirs_pkg::in_t mk_playable(int idx);
        int          r;
        logic [3:0]  kind;
        logic [15:0] count;
        logic [1:0]  width;
        logic [31:0] value;
        r = int'($urandom_range(0, 19));
        if (r < 2) kind = pirs_pkg::KIND_WAIT;
        else if (r < 5) kind = pirs_pkg::KIND_PRESS;
        else if (r < 7 || r > 17) kind = pirs_pkg::KIND_HOLD;
        else if (r < 10) kind = pirs_pkg::KIND_UNTIL;
        else if (r < 13) kind = pirs_pkg::KIND_SEEK;
        else if (r == 13) kind = pirs_pkg::KIND_SHOT;
        else if (r < 16) kind = pirs_pkg::KIND_POKE;
        else if (r == 16) kind = pirs_pkg::KIND_SKIP;
        else kind = 4'($urandom_range(9, 15));
        width = 2'($urandom_range(0, 3));
        value = $urandom;
        if ($urandom_range(0, 4) != 0) begin
            if (width == pirs_pkg::WIDTH_BYTE) value &= 32'h0000_00ff;
            else if (width == pirs_pkg::WIDTH_HALF) value &= 32'h0000_ffff;
        end
        if (kind == pirs_pkg::KIND_UNTIL || kind == pirs_pkg::KIND_SEEK)
            count = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom_range(0, 6));
        else if (kind == pirs_pkg::KIND_POKE || kind > pirs_pkg::KIND_END
                 || kind == pirs_pkg::KIND_SKIP)
            count = 16'($urandom);
        else
            count = 16'($urandom_range(0, 4));
        return mk_load(idx, kind, 16'($urandom), count, 8'($urandom_range(0, 3)),
                       8'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
                       width, value);
    endfunction

    // tick with a probe value that mostly meets the watched condition
    function automatic pirs_pkg::in_t mk_tick();
        pirs_pkg::in_t       x;
        pirs_pkg::step_rec_t c;
        x = '0;
        x.command = pirs_pkg::CMD_TICK;
        x.step_index = 6'($urandom);
        x.step_kind = 4'($urandom);
        x.step_buttons = 16'($urandom);
        x.step_value = $urandom;
        x.probe_value = $urandom;
        if (probe_ok && step_ptr < DEPTH && $urandom_range(0, 9) < 6) begin
            c = prog[step_ptr];
            x.probe_value = (c.op == pirs_pkg::OP_EQ || c.op == pirs_pkg::OP_ANY)
                            ? c.value : ~c.value;
        end
        return x;
    endfunction

    task automatic send_item(pirs_pkg::in_t x);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 5)) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= x;
        do @(posedge aclk); while (!s_ready);
        predict_frame(x);
    endtask

    task automatic write_length(logic [6:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        length_reg = v;
    endtask

    initial begin
        pirs_pkg::in_t tick_item;
        int  n_items;
        length_reg = '0;
        step_ptr = 0;
        frames_done = '0;
        is_playing = 1'b1;
        has_failed = 1'b0;
        probe_ok = 1'b0;
        word_now = '0;
        word_before = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // every slot but the last gets a playable step, the last an end step; the directed rows then overwrite the head
        for (int i = 0; i < DEPTH; i++)
            send_item(i == DEPTH - 1
                ? mk_load(i, pirs_pkg::KIND_END, '0, '0, 8'd1, '0, pirs_pkg::OP_EQ, '0,
                          pirs_pkg::WIDTH_BYTE, '0)
                : mk_playable(i));

        tick_item = mk_tick();
        add_row(1'b0, 7'd0, mk_load(0, pirs_pkg::KIND_POKE, 16'hffff, 16'hffff, 8'hff, 8'hff,
                                    2'd3, 32'hffff_ffff, 2'd3, 32'hffff_ffff));
        add_row(1'b0, 7'd0, mk_load(1, pirs_pkg::KIND_POKE, '0, '0, 8'd1, '0, pirs_pkg::OP_EQ,
                                    '0, pirs_pkg::WIDTH_BYTE, '0));
        add_row(1'b0, 7'd0, mk_load(2, pirs_pkg::KIND_HOLD, 16'hffff, 16'd2, 8'd1, '0,
                                    pirs_pkg::OP_EQ, '0, pirs_pkg::WIDTH_BYTE, '0));
        add_row(1'b0, 7'd0, mk_load(3, pirs_pkg::KIND_PRESS, 16'h00f0, 16'd2, 8'd1, 8'd1,
                                    pirs_pkg::OP_EQ, '0, pirs_pkg::WIDTH_BYTE, '0));
        // press with zero period finishes at once
        add_row(1'b0, 7'd0, mk_load(4, pirs_pkg::KIND_PRESS, 16'h0f0f, 16'd5, '0, '0,
                                    pirs_pkg::OP_EQ, '0, pirs_pkg::WIDTH_BYTE, '0));
        add_row(1'b0, 7'd0, mk_load(5, pirs_pkg::KIND_UNTIL, '0, 16'd3, 8'd1, '0,
                                    pirs_pkg::OP_EQ, 32'd100, pirs_pkg::WIDTH_BYTE, 32'h5a));
        add_row(1'b0, 7'd0, mk_load(6, pirs_pkg::KIND_SEEK, 16'h0001, 16'd4, 8'd2, 8'd1,
                                    pirs_pkg::OP_ANY, 32'h200, pirs_pkg::WIDTH_HALF,
                                    32'h8000));
        // seek with zero period checks every frame
        add_row(1'b0, 7'd0, mk_load(7, pirs_pkg::KIND_SEEK, 16'haaaa, 16'd3, '0, '0,
                                    pirs_pkg::OP_NE, 32'h300, pirs_pkg::WIDTH_WORD, '0));
        add_row(1'b0, 7'd0, mk_load(8, pirs_pkg::KIND_SHOT, 16'h5555, 16'd1, 8'd1, '0,
                                    pirs_pkg::OP_EQ, '0, pirs_pkg::WIDTH_BYTE, '0));
        add_row(1'b0, 7'd0, mk_load(9, pirs_pkg::KIND_WAIT, '0, 16'd2, 8'd1, '0,
                                    pirs_pkg::OP_EQ, '0, pirs_pkg::WIDTH_BYTE, '0));
        add_row(1'b0, 7'd0, mk_load(10, pirs_pkg::KIND_SKIP, '0, '0, 8'd1, '0,
                                    pirs_pkg::OP_EQ, '0, pirs_pkg::WIDTH_BYTE, '0));
        // unknown kind walks on like a skip
        add_row(1'b0, 7'd0, mk_load(11, 4'd15, 16'hffff, '0, 8'd1, '0, pirs_pkg::OP_EQ, '0,
                                    pirs_pkg::WIDTH_BYTE, '0));
        add_row(1'b0, 7'd0, mk_load(12, pirs_pkg::KIND_UNTIL, '0, 16'hffff, 8'd1, '0,
                                    pirs_pkg::OP_NONE, 32'h400, 2'd3, 32'h1));
        add_row(1'b1, 7'd127, tick_item);
        for (int i = 0; i < 10; i++) add_row(1'b0, 7'd0, tick_item);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) write_length(dir_tab[i].length);
            else if (dir_tab[i].item.command == pirs_pkg::CMD_TICK) send_item(mk_tick());
            else send_item(dir_tab[i].item);
        end

        n_items = 0;
        while (n_items < RANDOM_ITEMS) begin
            if (n_items == 50) write_length(7'd64);
            if (n_items == 100) write_length(7'($urandom_range(step_ptr + 1, 126)));
            if (n_items == 150) quiet = 1'b1;
            if ($urandom_range(0, 9) < 3) begin
                // slots already passed take fully random content
                if (step_ptr > 1 && $urandom_range(0, 1) == 0)
                    send_item(mk_load(int'($urandom_range(0, step_ptr - 1)), 4'($urandom),
                                      16'($urandom), 16'($urandom), 8'($urandom),
                                      8'($urandom), 2'($urandom), $urandom, 2'($urandom),
                                      $urandom));
                else if (step_ptr + 1 < DEPTH - 1)
                    send_item(mk_playable(int'($urandom_range(step_ptr + 1, DEPTH - 2))));
                else
                    send_item(mk_tick());
            end else begin
                send_item(mk_tick());
            end
            n_items++;
        end

        write_length(7'd0);
        repeat (3) send_item(mk_tick());
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/pirs_pkg.sv
sv/pirs_step_store.sv
sv/pirs_cond_unit.sv
sv/pad_input_recipe_sequencer_unit.sv
bench/pad_input_recipe_sequencer_unit_test.sv
